[rtl/ptu_pkg.sv]
`default_nettype none
package ptu_pkg;

    typedef struct packed {
        logic               mode;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic        [31:0] rgba;
        logic        [23:0] life_span;
        logic        [15:0] radius;
        logic        [15:0] delta_time;
    } t_in;

    typedef struct packed {
        logic        [1:0]  kind;
        logic        [5:0]  slot;
        logic signed [23:0] out_x;
        logic signed [23:0] out_y;
        logic        [31:0] out_rgba;
        logic        [15:0] out_radius;
        logic        [6:0]  live_count;
        logic               last;
    } t_out;

    // one table entry, all stores side by side in one word
    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic        [31:0] rgba;
        logic        [23:0] life;
        logic        [23:0] age;
        logic        [15:0] radius;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam logic MODE_EMIT = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [1:0] KIND_EMIT = 2'd0;
    localparam logic [1:0] KIND_DROP = 2'd1;
    localparam logic [1:0] KIND_LIVE = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

endpackage
`default_nettype wire

[rtl/ptu_ram.sv]
`default_nettype none
module ptu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/particle_table_update_top.sv]
`default_nettype none
// Particle table. An emit transfer stores a particle in the first free slot
// (or reports a drop when full) and gives one result once the output is free.
// A tick transfer walks the table in slot order: a dead particle passes the
// check, evaluate and move states, or only check and evaluate when it is the
// last one (swap-remove reads the last entry and writes it over the slot);
// a live one is aged and checked, then passes one multiply, one add/clamp, a
// restoring divide for the alpha byte and write-back. Every result carries
// the count after the whole tick, so the survivors are reported afterwards in
// a readout pass from slot 0 upward; an empty table gives one "none alive"
// result.
// All particle state sits in one single-port-write, registered-read RAM;
// only the count is reset. One item is in work at a time.
module particle_table_update_top #(
    parameter int MAX_PARTICLES = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ptu_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ptu_pkg::t_out      o_out_data
);
    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PARTICLES);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_EMIT  = 11'b00000000010,
        S_CHK   = 11'b00000000100,
        S_EVAL  = 11'b00000001000,
        S_MOVE  = 11'b00000010000,
        S_MUL   = 11'b00000100000,
        S_ADD   = 11'b00001000000,
        S_DIV   = 11'b00010000000,
        S_WB    = 11'b00100000000,
        S_OSTRT = 11'b01000000000,
        S_OSEND = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    ptu_pkg::t_in    r_in;
    ptu_pkg::t_entry r_ent;
    ptu_pkg::t_out   r_out;
    logic            r_ov;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_i;
    logic [15:0]     r_dt;
    logic signed [40:0] r_prod_x, r_prod_y;
    logic [31:0]     r_rem;
    logic [7:0]      r_q;
    logic [2:0]      r_bit;
    logic            r_rd_pend;

    logic                         ram_we, ram_re;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    logic [ptu_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;
    ptu_pkg::t_entry              rd_ent, new_ent, aged_ent;

    logic        out_free;
    logic        ov_set;
    logic [24:0] age_sum;
    logic [23:0] age_sat;
    logic        dead;
    logic [23:0] diff;
    logic [31:0] div_d;
    logic signed [25:0] sum_x, sum_y;

    ptu_ram #(
        .WIDTH (ptu_pkg::ENTRY_W),
        .DEPTH (MAX_PARTICLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_ent   = ptu_pkg::t_entry'(ram_rdata);
    assign out_free = !r_ov || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // load the output register in these states once it is free
    assign ov_set = out_free && ((r_state == S_EMIT) || (r_state == S_OSEND) ||
                                 ((r_state == S_OSTRT) && (r_cnt == '0)));

    // age step with saturation; zero lifetime is always dead
    assign age_sum = {1'b0, rd_ent.age} + {9'd0, r_dt};
    assign age_sat = age_sum[24] ? 24'hFFFFFF : age_sum[23:0];
    assign dead    = (age_sat >= rd_ent.life);
    assign diff    = r_ent.life - r_ent.age;
    assign div_d   = {8'd0, r_ent.life} << r_bit;

    // floor of product / 65536 is an arithmetic shift
    assign sum_x = 26'(r_ent.pos_x) + 26'(r_prod_x >>> 16);
    assign sum_y = 26'(r_ent.pos_y) + 26'(r_prod_y >>> 16);

    always_comb begin
        aged_ent     = rd_ent;
        aged_ent.age = age_sat;
    end

    always_comb begin
        new_ent        = '0;
        new_ent.pos_x  = r_in.pos_x;
        new_ent.pos_y  = r_in.pos_y;
        new_ent.vel_x  = r_in.vel_x;
        new_ent.vel_y  = r_in.vel_y;
        new_ent.rgba   = r_in.rgba;
        new_ent.life   = r_in.life_span;
        new_ent.age    = '0;
        new_ent.radius = r_in.radius;
    end

    // RAM port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_i[AW-1:0];
        ram_wdata = r_ent;
        ram_re    = 1'b0;
        ram_raddr = r_i[AW-1:0];
        unique case (r_state)
            S_EMIT: begin
                ram_we    = out_free && (r_cnt < CNT_MAX);
                ram_waddr = r_cnt[AW-1:0];
                ram_wdata = new_ent;
            end
            S_CHK: begin
                ram_re = (r_i < r_cnt);
            end
            S_EVAL: begin
                ram_re    = dead;
                ram_raddr = AW'(r_cnt - CW'(1));
            end
            S_MOVE: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            S_WB: begin
                ram_we = 1'b1;
            end
            S_OSTRT: begin
                ram_re = (r_cnt != '0) && !r_rd_pend;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_data.mode == ptu_pkg::MODE_TICK) ? S_CHK : S_EMIT;
                end
            end
            S_EMIT:  if (out_free) n_state = S_IDLE;
            S_CHK:   n_state = (r_i < r_cnt) ? S_EVAL : S_OSTRT;
            S_EVAL: begin
                if (!dead)                          n_state = S_MUL;
                else if (r_i == r_cnt - CW'(1))     n_state = S_CHK;
                else                                n_state = S_MOVE;
            end
            S_MOVE:  n_state = S_CHK;
            S_MUL:   n_state = S_ADD;
            S_ADD:   n_state = S_DIV;
            S_DIV:   if (r_bit == 3'd0) n_state = S_WB;
            S_WB:    n_state = S_CHK;
            S_OSTRT: begin
                if (r_cnt == '0) begin
                    if (out_free) n_state = S_IDLE;
                end else if (r_rd_pend) begin
                    n_state = S_OSEND;
                end
            end
            S_OSEND: begin
                if (out_free) n_state = (r_i == r_cnt - CW'(1)) ? S_IDLE : S_OSTRT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_ov      <= 1'b0;
            r_i       <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ov_set) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_in      <= i_in_data;
                    r_dt      <= i_in_data.delta_time;
                    r_i       <= '0;
                    r_rd_pend <= 1'b0;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out.last       <= 1'b1;
                        if (r_cnt < CNT_MAX) begin
                            r_cnt            <= r_cnt + CW'(1);
                            r_out.kind       <= ptu_pkg::KIND_EMIT;
                            r_out.slot       <= 6'(r_cnt);
                            r_out.out_x      <= r_in.pos_x;
                            r_out.out_y      <= r_in.pos_y;
                            r_out.out_rgba   <= r_in.rgba;
                            r_out.out_radius <= r_in.radius;
                            r_out.live_count <= 7'(r_cnt + CW'(1));
                        end else begin
                            r_out.kind       <= ptu_pkg::KIND_DROP;
                            r_out.slot       <= '0;
                            r_out.out_x      <= '0;
                            r_out.out_y      <= '0;
                            r_out.out_rgba   <= '0;
                            r_out.out_radius <= '0;
                            r_out.live_count <= 7'(r_cnt);
                        end
                    end
                end
                S_CHK: begin
                    // walk over: restart the index for the readout pass
                    if (!(r_i < r_cnt)) r_i <= '0;
                end
                S_EVAL: begin
                    if (dead) begin
                        r_cnt <= r_cnt - CW'(1);
                    end else begin
                        r_ent <= aged_ent;
                    end
                end
                S_MUL: begin
                    r_prod_x <= 41'(r_ent.vel_x) * 41'($signed({1'b0, r_dt}));
                    r_prod_y <= 41'(r_ent.vel_y) * 41'($signed({1'b0, r_dt}));
                    r_rem    <= ({8'd0, diff} << 8) - {8'd0, diff};
                    r_bit    <= 3'd7;
                    r_q      <= '0;
                end
                S_ADD: begin
                    // clamp to the signed 24-bit range
                    if (sum_x > 26'sd8388607)       r_ent.pos_x <= 24'sh7FFFFF;
                    else if (sum_x < -26'sd8388608) r_ent.pos_x <= 24'sh800000;
                    else                            r_ent.pos_x <= sum_x[23:0];
                    if (sum_y > 26'sd8388607)       r_ent.pos_y <= 24'sh7FFFFF;
                    else if (sum_y < -26'sd8388608) r_ent.pos_y <= 24'sh800000;
                    else                            r_ent.pos_y <= sum_y[23:0];
                end
                S_DIV: begin
                    // one quotient bit a cycle, quotient stays below 256
                    if (r_rem >= div_d) begin
                        r_rem      <= r_rem - div_d;
                        r_q[r_bit] <= 1'b1;
                        if (r_bit == 3'd0) r_ent.rgba[7:0] <= r_q | 8'd1;
                    end else if (r_bit == 3'd0) begin
                        r_ent.rgba[7:0] <= r_q;
                    end
                    r_bit <= r_bit - 3'd1;
                end
                S_WB: begin
                    r_i <= r_i + CW'(1);
                end
                S_OSTRT: begin
                    if (r_cnt == '0) begin
                        if (out_free) begin
                            r_out.kind       <= ptu_pkg::KIND_NONE;
                            r_out.slot       <= '0;
                            r_out.out_x      <= '0;
                            r_out.out_y      <= '0;
                            r_out.out_rgba   <= '0;
                            r_out.out_radius <= '0;
                            r_out.live_count <= '0;
                            r_out.last       <= 1'b1;
                        end
                    end else begin
                        r_rd_pend <= !r_rd_pend;
                    end
                end
                S_OSEND: begin
                    r_rd_pend <= 1'b0;
                    if (out_free) begin
                        r_out.kind       <= ptu_pkg::KIND_LIVE;
                        r_out.slot       <= 6'(r_i);
                        r_out.out_x      <= rd_ent.pos_x;
                        r_out.out_y      <= rd_ent.pos_y;
                        r_out.out_rgba   <= rd_ent.rgba;
                        r_out.out_radius <= rd_ent.radius;
                        r_out.live_count <= 7'(r_cnt);
                        r_out.last       <= (r_i == r_cnt - CW'(1));
                        r_i              <= r_i + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[tb/particle_table_update_checker.sv]
`timescale 1ns / 100ps
// Watches both channels, keeps its own copy of the particle table and
// compares every result transfer with the oldest prediction.
module particle_table_update_checker #(
    parameter int MAX_PARTICLES = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_ready,
    input  wire ptu_pkg::t_in   i_in_data,
    input  wire logic           i_out_valid,
    input  wire logic           i_out_ready,
    input  wire ptu_pkg::t_out  i_out_data,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_live_reports,
    output int                  o_drops,
    output int                  o_empty_ticks
);
    ptu_pkg::t_entry particles [MAX_PARTICLES];
    int              occupancy;
    ptu_pkg::t_out   awaited [$];

    function automatic logic signed [23:0] advance_axis(logic signed [23:0] p,
                                                        logic signed [23:0] v,
                                                        logic [15:0] dt);
        longint prod;
        longint s;
        prod = longint'(v) * longint'({1'b0, dt});
        s = longint'(p) + (prod >>> 16);
        if (s > 64'sd8388607) s = 64'sd8388607;
        if (s < -64'sd8388608) s = -64'sd8388608;
        return s[23:0];
    endfunction

    task automatic predict_item(input ptu_pkg::t_in it);
        ptu_pkg::t_out   batch [$];
        ptu_pkg::t_out   r;
        ptu_pkg::t_entry e;
        logic [24:0] aged;
        longint alpha;
        int i;
        if (it.mode == ptu_pkg::MODE_EMIT) begin
            r = '0;
            if (occupancy >= MAX_PARTICLES) begin
                r.kind = ptu_pkg::KIND_DROP;
            end else begin
                e.pos_x  = it.pos_x;
                e.pos_y  = it.pos_y;
                e.vel_x  = it.vel_x;
                e.vel_y  = it.vel_y;
                e.rgba   = it.rgba;
                e.life   = it.life_span;
                e.age    = '0;
                e.radius = it.radius;
                particles[occupancy] = e;
                r.kind       = ptu_pkg::KIND_EMIT;
                r.slot       = 6'(occupancy);
                r.out_x      = it.pos_x;
                r.out_y      = it.pos_y;
                r.out_rgba   = it.rgba;
                r.out_radius = it.radius;
                occupancy++;
            end
            batch.push_back(r);
        end else begin
            i = 0;
            while (i < occupancy) begin
                e = particles[i];
                aged = {1'b0, e.age} + {9'b0, it.delta_time};
                if (aged[24]) aged = 25'hFF_FFFF;
                if (aged[23:0] >= e.life) begin
                    // swap-remove: last entry fills this slot, look again
                    particles[i] = particles[occupancy - 1];
                    occupancy--;
                    continue;
                end
                e.pos_x = advance_axis(e.pos_x, e.vel_x, it.delta_time);
                e.pos_y = advance_axis(e.pos_y, e.vel_y, it.delta_time);
                alpha = (longint'(255) * longint'(e.life - aged[23:0])) / longint'(e.life);
                e.rgba[7:0] = alpha[7:0];
                e.age = aged[23:0];
                particles[i] = e;
                r = '0;
                r.kind       = ptu_pkg::KIND_LIVE;
                r.slot       = 6'(i);
                r.out_x      = e.pos_x;
                r.out_y      = e.pos_y;
                r.out_rgba   = e.rgba;
                r.out_radius = e.radius;
                batch.push_back(r);
                i++;
            end
            if (batch.size() == 0) begin
                r = '0;
                r.kind = ptu_pkg::KIND_NONE;
                batch.push_back(r);
            end
        end
        foreach (batch[k]) begin
            batch[k].live_count = 7'(occupancy);
            batch[k].last = (k == batch.size() - 1);
            awaited.push_back(batch[k]);
        end
    endtask

    task automatic compare_result(input ptu_pkg::t_out got);
        ptu_pkg::t_out want;
        if (awaited.size() == 0) begin
            $display("%0t: result with nothing awaited: %p", $time, got);
            o_errors++;
        end else begin
            want = awaited.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch expected %p actual %p", $time, want, got);
                o_errors++;
            end
            case (got.kind)
                ptu_pkg::KIND_LIVE: o_live_reports++;
                ptu_pkg::KIND_DROP: o_drops++;
                ptu_pkg::KIND_NONE: o_empty_ticks++;
                default: ;
            endcase
        end
    endtask

    initial begin
        o_errors = 0;
        o_live_reports = 0;
        o_drops = 0;
        o_empty_ticks = 0;
        occupancy = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            occupancy = 0;
            awaited.delete();
        end else begin
            if (i_in_valid && i_in_ready) predict_item(i_in_data);
            if (i_out_valid && i_out_ready) compare_result(i_out_data);
        end
        o_pending = awaited.size();
    end

endmodule

[tb/particle_table_update_top_tb.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for the particle table. Prediction and checking
// live in the checker beside the block.
module particle_table_update_top_tb;
    localparam int  MAX_PARTICLES = 64;
    localparam int  RANDOM_ITEMS  = 300;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  IN_W          = $bits(ptu_pkg::t_in);
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    ptu_pkg::t_in   in_data;
    logic           out_valid;
    logic           out_ready;
    ptu_pkg::t_out  out_data;

    int     errors, pending, live_reports, drops, empty_ticks;
    int     items_sent;
    bit     idling_on;   // cleared for a stretch of back-to-back transfers
    bit     hold_req;    // asks the receiver for one long hold-off
    longint cycles;

    particle_table_update_top #(.MAX_PARTICLES(MAX_PARTICLES)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    particle_table_update_checker #(.MAX_PARTICLES(MAX_PARTICLES)) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_live_reports(live_reports),
        .o_drops       (drops),
        .o_empty_ticks (empty_ticks)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Guard the whole run; a hang anywhere ends here.
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request so that the
    // block backs up and refuses further input transfers.
    initial begin
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                out_ready <= !(idling_on && $urandom_range(0, 99) < 33);
                @(posedge clk);
            end
        end
    end

    // Offer one transfer; hold valid and payload until accepted. Valid is
    // only dropped when a gap is taken, so it never toggles within a step.
    task automatic offer(input ptu_pkg::t_in item);
        if (idling_on && $urandom_range(0, 99) < 33) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < 33) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [23:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 24'h7F_FFFF;
            1:       return 24'h80_0000;
            2, 3, 4: return 24'($urandom);
            default: return 24'($signed($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    function automatic ptu_pkg::t_in build_emit();
        ptu_pkg::t_in it;
        it            = ptu_pkg::t_in'(IN_W'({$urandom, $urandom, $urandom,
                                                $urandom, $urandom, $urandom}));
        it.mode       = ptu_pkg::MODE_EMIT;
        it.pos_x      = pick_coord();
        it.pos_y      = pick_coord();
        it.vel_x      = pick_coord();
        it.vel_y      = pick_coord();
        it.rgba       = $urandom;
        it.radius     = 16'($urandom);
        case ($urandom_range(0, 19))
            0:       it.life_span = 24'($urandom);
            1:       it.life_span = 24'h0;
            2:       it.life_span = 24'hFF_FFFF;
            3, 4:    it.life_span = 24'($urandom_range(1, 16'h2000));
            default: it.life_span = 24'($urandom_range(16'h4000, 24'h3_0000));
        endcase
        return it;
    endfunction

    function automatic ptu_pkg::t_in build_tick(input logic [15:0] step);
        ptu_pkg::t_in it;
        it            = ptu_pkg::t_in'(IN_W'({$urandom, $urandom, $urandom,
                                                $urandom, $urandom, $urandom}));
        it.mode       = ptu_pkg::MODE_TICK;
        it.delta_time = step;
        return it;
    endfunction

    function automatic ptu_pkg::t_in build_emit_fixed(input logic [23:0] p,
                                                      input logic [23:0] v,
                                                      input logic [31:0] c,
                                                      input logic [23:0] life,
                                                      input logic [15:0] rad);
        ptu_pkg::t_in it;
        it           = '0;
        it.mode      = ptu_pkg::MODE_EMIT;
        it.pos_x     = p;
        it.pos_y     = ~p;
        it.vel_x     = v;
        it.vel_y     = ~v;
        it.rgba      = c;
        it.life_span = life;
        it.radius    = rad;
        return it;
    endfunction

    initial begin
        ptu_pkg::t_in it;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        idling_on  = 1'b1;
        hold_req   = 1'b0;
        items_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty tick, field extremes, clamping, zero lifetime,
        // exact expiry, zero and full steps.
        offer(build_tick(16'hFFFF));
        offer(build_emit_fixed(24'h7F_FFFF, 24'h7F_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF));
        offer(build_emit_fixed(24'h80_0000, 24'h80_0000, 32'h0, 24'h0, 16'h0));
        offer(build_emit_fixed(24'h00_0100, 24'hFF_FF01, 32'h1234_5678, 24'h1, 16'h0180));
        offer(build_emit_fixed(24'hFF_FFFF, 24'h00_0001, 32'hA5A5_A5A5, 24'h2_0000, 16'h8000));
        offer(build_tick(16'h0000));
        offer(build_tick(16'hFFFF));
        offer(build_tick(16'h0001));
        offer(build_tick(16'h8000));
        offer(build_tick(16'hFFFF));
        offer(build_tick(16'hFFFF));

        // Fill the table past capacity, then tick it down.
        repeat (MAX_PARTICLES + 2) offer(build_emit());
        offer(build_tick(16'h0100));
        hold_req = 1'b1;   // receiver backs off while the sender keeps offering
        repeat (4) offer(build_tick(16'($urandom_range(16'h4000, 16'hFFFF))));
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);   // sender pause until all drained
        repeat (20) @(posedge clk);

        // Random part: bursts of emits mixed with ticks, one stretch without gaps or stalls.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idling_on = !(n >= 120 && n < 200);
            if ($urandom_range(0, 99) < 35) begin
                case ($urandom_range(0, 9))
                    0:       it = build_tick(16'hFFFF);
                    1:       it = build_tick(16'h0000);
                    default: it = build_tick(16'($urandom));
                endcase
            end else begin
                it = build_emit();
            end
            offer(it);
        end
        idling_on = 1'b1;
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);

        $display("%0d input transfers: %0d live reports, %0d dropped emits, %0d empty ticks",
                 items_sent, live_reports, drops, empty_ticks);
        $display("covered table fill and overflow, swap-removal, clamped motion, long output stall");
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
